### design/lwpt_pkg.sv
// Package with the transfer types and fixed constants of the lane wait priority tracker.
package lwpt_pkg;

    localparam int DIR_W  = 2;
    localparam int CNT_W  = 8;
    localparam int PRIO_W = 11;

    localparam logic [PRIO_W-1:0] PRIO_MAX = 11'd2047;

    typedef struct packed {
        logic [DIR_W-1:0] direction;
        logic [CNT_W-1:0] arrivals;
        logic [CNT_W-1:0] departures;
    } item_t;

    typedef struct packed {
        logic [DIR_W-1:0]  lane;
        logic [PRIO_W-1:0] priority_res;
        logic [PRIO_W-1:0] mean_priority;
    } res_t;

    function automatic logic [CNT_W-1:0] floor_sub(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W-1:0] r;
        begin
            r = (a > b) ? (a - b) : '0;
            return r;
        end
    endfunction

endpackage

### design/lane_wait_priority_tracker_unit.sv
// Top level of the lane wait priority tracker: sequencer, shared accumulator and stores.
// The next input transfer is taken in the cycle after the result is registered, and a
// stalled result holds off the next one. The history update reads and then writes the
// history RAM slot by slot, the ring sum reads one ring RAM entry per cycle, and the
// divider resolves one quotient bit per cycle.
// Reset clears the control state, stored arrival counts, history fill counts and ring pointers;
// the RAMs need no clearing pass since unwritten entries are never used.
module lane_wait_priority_tracker_unit #(
    parameter int DIRECTIONS    = 4,
    parameter int HISTORY_DEPTH = 6,
    parameter int RING_DEPTH    = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  lwpt_pkg::item_t item,
    output logic            res_valid,
    input  logic            res_stall,
    output lwpt_pkg::res_t  res
);

    import lwpt_pkg::*;

    localparam int DW     = (DIRECTIONS > 1) ? $clog2(DIRECTIONS) : 1;
    localparam int KW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HFW    = $clog2(HISTORY_DEPTH + 1);
    localparam int HDEPTH = DIRECTIONS * HISTORY_DEPTH;
    localparam int HAW    = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
    localparam int RHW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW     = $clog2(RING_DEPTH + 1);
    localparam int RDEPTH = DIRECTIONS * RING_DEPTH;
    localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int HSUM_W = $clog2((HISTORY_DEPTH + 1) * 255 + 1);
    localparam int RSUM_W = $clog2(RING_DEPTH * 2047 + 1);
    localparam int AW0    = (HSUM_W > RSUM_W) ? HSUM_W : RSUM_W;
    localparam int AW     = (AW0 > PRIO_W + 1) ? AW0 : PRIO_W + 1;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_HRD  = 9'b000000010,
        S_HWR  = 9'b000000100,
        S_HNEW = 9'b000001000,
        S_PRIO = 9'b000010000,
        S_RWR  = 9'b000100000,
        S_RSUM = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    item_t             item_reg;
    logic [DW-1:0]     dir_idx;
    logic              dir_ok;
    logic [HAW-1:0]    hbase_reg;
    logic [RAW-1:0]    rbase_reg;
    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     k_next;
    logic [KW-1:0]     km1;
    logic [FW-1:0]     j_reg;
    logic [FW-1:0]     j_next;
    logic [FW-1:0]     cnt_reg;
    logic              pend_reg;
    logic              pend_next;
    logic [AW-1:0]     acc_reg;
    logic [AW-1:0]     acc_next;
    logic [AW-1:0]     add_sum;
    logic [PRIO_W-1:0] add_b;
    logic [CNT_W-1:0]  old_val;
    logic [CNT_W-1:0]  nv;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] mean_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    logic              accept;
    logic              out_load;
    logic              sum_done;

    logic [CNT_W-1:0]  last_arr_reg [DIRECTIONS];
    logic [HFW-1:0]    hfill_reg    [DIRECTIONS];
    logic [RHW-1:0]    head_reg     [DIRECTIONS];
    logic [FW-1:0]     fill_reg     [DIRECTIONS];

    logic              h_we;
    logic [HAW-1:0]    h_waddr;
    logic [HAW-1:0]    h_raddr;
    logic [CNT_W-1:0]  h_rdata;
    logic              r_we;
    logic [RAW-1:0]    r_waddr;
    logic [RAW-1:0]    r_raddr;
    logic [PRIO_W-1:0] r_rdata;
    logic              div_start;
    logic              div_done;
    logic [AW-1:0]     div_q;

    assign accept     = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);
    assign dir_idx    = DW'(item_reg.direction);
    assign dir_ok     = int'(item_reg.direction) < DIRECTIONS;
    assign km1        = k_reg - KW'(1);
    assign out_load   = (state_reg == S_OUT) && (!res_valid_reg || !res_stall);
    assign sum_done   = (j_reg == cnt_reg) && !pend_reg;

    lwpt_ram #(.WIDTH(CNT_W), .DEPTH(HDEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (nv),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    lwpt_ram #(.WIDTH(PRIO_W), .DEPTH(RDEPTH)) u_ring_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (prio_reg),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    lwpt_div #(.N_W(AW), .D_W(FW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign h_we      = (state_reg == S_HWR) || (state_reg == S_HNEW);
    assign h_waddr   = (state_reg == S_HNEW) ? hbase_reg : hbase_reg + HAW'(k_reg);
    assign h_raddr   = hbase_reg + HAW'(km1);
    assign r_we      = (state_reg == S_RWR);
    assign r_waddr   = rbase_reg + RAW'(head_reg[dir_idx]);
    assign r_raddr   = rbase_reg + RAW'(j_reg);
    assign div_start = (state_reg == S_RSUM) && sum_done;

    always_comb
    begin
        if (state_reg == S_HNEW)
        begin
            old_val = last_arr_reg[dir_idx];
        end
        else if (HFW'(km1) < hfill_reg[dir_idx])
        begin
            old_val = h_rdata;
        end
        else
        begin
            old_val = '0;
        end
    end

    assign nv = floor_sub(old_val, item_reg.departures);

    always_comb
    begin
        unique case (state_reg)
            S_HWR, S_HNEW: add_b = PRIO_W'(nv);
            S_PRIO:        add_b = PRIO_W'(item_reg.arrivals);
            default:       add_b = r_rdata;
        endcase
    end

    assign add_sum = acc_reg + AW'(add_b);

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        pend_next  = 1'b0;
        acc_next   = acc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                acc_next = '0;
                k_next   = KW'(HISTORY_DEPTH - 1);
                if (accept)
                begin
                    if (int'(item.direction) >= DIRECTIONS)
                    begin
                        state_next = S_OUT;
                    end
                    else if (HISTORY_DEPTH == 1)
                    begin
                        state_next = S_HNEW;
                    end
                    else
                    begin
                        state_next = S_HRD;
                    end
                end
            end
            S_HRD:
            begin
                state_next = S_HWR;
            end
            S_HWR:
            begin
                acc_next   = add_sum;
                k_next     = km1;
                state_next = (k_reg == KW'(1)) ? S_HNEW : S_HRD;
            end
            S_HNEW:
            begin
                acc_next   = add_sum;
                state_next = S_PRIO;
            end
            S_PRIO:
            begin
                state_next = S_RWR;
            end
            S_RWR:
            begin
                acc_next   = '0;
                j_next     = '0;
                state_next = S_RSUM;
            end
            S_RSUM:
            begin
                if (pend_reg)
                begin
                    acc_next = add_sum;
                end
                if (j_reg != cnt_reg)
                begin
                    j_next    = j_reg + FW'(1);
                    pend_next = 1'b1;
                end
                if (sum_done)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < DIRECTIONS; i++)
            begin
                last_arr_reg[i] <= '0;
                hfill_reg[i]    <= '0;
                head_reg[i]     <= '0;
                fill_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (out_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == S_PRIO)
            begin
                last_arr_reg[dir_idx] <= item_reg.arrivals;
                if (hfill_reg[dir_idx] != HFW'(HISTORY_DEPTH))
                begin
                    hfill_reg[dir_idx] <= hfill_reg[dir_idx] + HFW'(1);
                end
            end
            if (state_reg == S_RWR)
            begin
                if (head_reg[dir_idx] == RHW'(RING_DEPTH - 1))
                begin
                    head_reg[dir_idx] <= '0;
                end
                else
                begin
                    head_reg[dir_idx] <= head_reg[dir_idx] + RHW'(1);
                end
                if (fill_reg[dir_idx] != FW'(RING_DEPTH))
                begin
                    fill_reg[dir_idx] <= fill_reg[dir_idx] + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg   <= k_next;
        j_reg   <= j_next;
        acc_reg <= acc_next;
        if (accept)
        begin
            item_reg  <= item;
            hbase_reg <= HAW'(32'(DW'(item.direction)) * HISTORY_DEPTH);
            rbase_reg <= RAW'(32'(DW'(item.direction)) * RING_DEPTH);
            prio_reg  <= '0;
            mean_reg  <= '0;
        end
        if (state_reg == S_PRIO)
        begin
            prio_reg <= (add_sum > AW'(PRIO_MAX)) ? PRIO_MAX : add_sum[PRIO_W-1:0];
        end
        if (state_reg == S_RWR)
        begin
            cnt_reg <= (fill_reg[dir_idx] != FW'(RING_DEPTH)) ?
                       fill_reg[dir_idx] + FW'(1) : fill_reg[dir_idx];
        end
        if ((state_reg == S_DIV) && div_done)
        begin
            mean_reg <= div_q[PRIO_W-1:0];
        end
        if (out_load)
        begin
            res_reg.lane          <= item_reg.direction;
            res_reg.priority_res  <= dir_ok ? prio_reg : '0;
            res_reg.mean_priority <= dir_ok ? mean_reg : '0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### design/lwpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lwpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 24
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/lwpt_div.sv
// Restoring divider that produces one quotient bit per cycle.
module lwpt_div #(
    parameter int N_W = 14,
    parameter int D_W = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CW = $clog2(N_W + 1);

    logic           busy_reg;
    logic           busy_next;
    logic           done_reg;
    logic           done_next;
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_next;
    logic [N_W-1:0] q_reg;
    logic [N_W-1:0] q_next;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] rem_next;
    logic [D_W-1:0] d_reg;
    logic [D_W-1:0] d_next;
    logic [D_W:0]   rem_sh;
    logic [D_W:0]   diff;
    logic           ge;

    assign rem_sh = {rem_reg, q_reg[N_W-1]};
    assign ge     = rem_sh >= {1'b0, d_reg};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[N_W-2:0], ge};
            rem_next = ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
